FILE: design/b2r_pkg.sv
// Shared types and constants for the BMP row to RGB565 converter.
package b2r_pkg;

	localparam int WIDTH_W    = 13;
	localparam int DEPTH_W    = 6;
	localparam int CFG_DATA_W = 13;
	localparam int ROW_BYTES_W = 16;

	localparam logic [0:0] REG_WIDTH = 1'b0;
	localparam logic [0:0] REG_DEPTH = 1'b1;

	localparam logic [DEPTH_W-1:0] BPP_MONO  = 6'd1;
	localparam logic [DEPTH_W-1:0] BPP_TRUE  = 6'd24;
	localparam logic [DEPTH_W-1:0] BPP_ALPHA = 6'd32;

	localparam logic [WIDTH_W-1:0] RESET_WIDTH = 13'd320;
	localparam logic [DEPTH_W-1:0] RESET_DEPTH = 6'd24;

	localparam logic [1:0] SLOT_B = 2'd0;
	localparam logic [1:0] SLOT_G = 2'd1;
	localparam logic [1:0] SLOT_R = 2'd2;
	localparam logic [1:0] SLOT_X = 2'd3;

	localparam logic [15:0] WHITE = 16'hFFFF;
	localparam logic [15:0] BLACK = 16'h0000;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_image;
	} byte_item_t;

	typedef struct packed {
		logic [15:0] pixel_rgb565;
		logic        row_end;
		logic        last_of_item;
	} pixel_item_t;

	// One queued job: a mono byte to expand, or one finished color pixel.
	typedef struct packed {
		logic        mono;
		logic [15:0] data;
		logic [2:0]  last_idx;
		logic        row_end;
	} job_t;

endpackage

FILE: design/b2r_front.sv
// Front end: takes bytes, tracks row position and turns each mono byte or finished color pixel into a job.
module b2r_front #(
	parameter int MAX_ROW_BYTES = 960
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           full,
	input  b2r_pkg::byte_item_t            byte_item,
	input  logic                           cfg_we,
	input  logic [0:0]                     cfg_idx,
	input  logic [b2r_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic                           job_push,
	output b2r_pkg::job_t                  job
);

	localparam int BIR_W  = $clog2(MAX_ROW_BYTES);
	localparam int BIRC_W = $clog2(MAX_ROW_BYTES + 1);

	logic [b2r_pkg::WIDTH_W-1:0] width_q;
	logic [b2r_pkg::DEPTH_W-1:0] bpp_q;
	logic [BIR_W-1:0]            bir_q;
	logic [b2r_pkg::WIDTH_W-1:0] pix_q;
	logic [1:0]                  slot_q;
	logic [15:0]                 held_q;

	logic                              accept;
	logic                              first;
	logic [7:0]                        d;
	logic [BIR_W-1:0]                  bir_e;
	logic [b2r_pkg::WIDTH_W-1:0]       pix_e;
	logic [1:0]                        slot_e;
	logic [15:0]                       held_e;
	logic                              is_mono;
	logic                              is_true;
	logic                              is_alpha;
	logic [17:0]                       prod;
	logic [18:0]                       rb_sum;
	logic [b2r_pkg::ROW_BYTES_W-1:0]   row_bytes;
	logic                              row_ok;
	logic                              in_width;
	logic [b2r_pkg::WIDTH_W-1:0]       remain;
	logic [3:0]                        mono_n;
	logic                              emit;
	logic [BIRC_W-1:0]                 bir_inc;
	logic [BIR_W-1:0]                  bir_n;
	logic [b2r_pkg::WIDTH_W-1:0]       pix_n;
	logic [1:0]                        slot_n;
	logic [15:0]                       held_n;

	assign accept = push && !full;
	assign first  = byte_item.first_of_image;
	assign d      = byte_item.data_byte;

	assign bir_e  = first ? '0 : bir_q;
	assign pix_e  = first ? '0 : pix_q;
	assign slot_e = first ? b2r_pkg::SLOT_B : slot_q;
	assign held_e = first ? '0 : held_q;

	assign is_mono  = (bpp_q == b2r_pkg::BPP_MONO);
	assign is_true  = (bpp_q == b2r_pkg::BPP_TRUE);
	assign is_alpha = (bpp_q == b2r_pkg::BPP_ALPHA);

	// Padded row length: bits per row rounded up to whole 32-bit words.
	always_comb begin
		case (1'b1)
			is_mono:  prod = {5'd0, width_q};
			is_true:  prod = {1'b0, width_q, 4'd0} + {2'd0, width_q, 3'd0};
			default:  prod = {width_q, 5'd0};
		endcase
	end

	assign rb_sum    = {1'b0, prod} + 19'd31;
	assign row_bytes = {rb_sum[18:5], 2'b00};
	assign row_ok    = (is_mono || is_true || is_alpha) && (row_bytes != '0)
		&& (row_bytes <= b2r_pkg::ROW_BYTES_W'(MAX_ROW_BYTES));

	assign in_width = (pix_e < width_q);
	assign remain   = width_q - pix_e;
	assign mono_n   = (remain >= 13'd8) ? 4'd8 : remain[3:0];
	assign bir_inc  = BIRC_W'(bir_e) + BIRC_W'(1);

	always_comb begin
		pix_n  = pix_e;
		slot_n = slot_e;
		held_n = held_e;
		emit   = 1'b0;
		job    = '0;
		if (is_mono) begin
			if (in_width) begin
				emit         = 1'b1;
				pix_n        = pix_e + b2r_pkg::WIDTH_W'(mono_n);
				job.mono     = 1'b1;
				job.data     = {8'd0, d};
				job.last_idx = 3'(mono_n - 4'd1);
				job.row_end  = (remain <= 13'd8);
			end
		end else if (in_width) begin
			case (slot_e)
				b2r_pkg::SLOT_B: begin
					held_n[7:0] = d;
					slot_n      = b2r_pkg::SLOT_G;
				end
				b2r_pkg::SLOT_G: begin
					held_n[15:8] = d;
					slot_n       = b2r_pkg::SLOT_R;
				end
				b2r_pkg::SLOT_R: begin
					emit        = 1'b1;
					pix_n       = pix_e + 13'd1;
					job.data    = {d[7:3], held_e[15:10], held_e[7:3]};
					job.row_end = (remain == 13'd1);
					slot_n      = is_alpha ? b2r_pkg::SLOT_X : b2r_pkg::SLOT_B;
				end
				default: begin
					slot_n = b2r_pkg::SLOT_B;
				end
			endcase
		end else if (slot_e == b2r_pkg::SLOT_X) begin
			slot_n = b2r_pkg::SLOT_B;
		end

		// The last byte of a padded row, or any byte past a shortened row, wraps the row.
		bir_n = bir_inc[BIR_W-1:0];
		if (b2r_pkg::ROW_BYTES_W'(bir_inc) >= row_bytes) begin
			bir_n  = '0;
			pix_n  = '0;
			slot_n = b2r_pkg::SLOT_B;
		end
	end

	assign job_push = accept && row_ok && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= b2r_pkg::RESET_WIDTH;
			bpp_q   <= b2r_pkg::RESET_DEPTH;
		end else if (cfg_we) begin
			case (cfg_idx)
				b2r_pkg::REG_WIDTH: width_q <= cfg_wdata[b2r_pkg::WIDTH_W-1:0];
				b2r_pkg::REG_DEPTH: bpp_q   <= cfg_wdata[b2r_pkg::DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bir_q  <= '0;
			pix_q  <= '0;
			slot_q <= b2r_pkg::SLOT_B;
			held_q <= '0;
		end else if (accept) begin
			if (row_ok) begin
				bir_q  <= bir_n;
				pix_q  <= pix_n;
				slot_q <= slot_n;
				held_q <= held_n;
			end else if (first) begin
				bir_q  <= '0;
				pix_q  <= '0;
				slot_q <= b2r_pkg::SLOT_B;
				held_q <= '0;
			end
		end
	end

	a_bir_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		BIRC_W'(bir_q) < BIRC_W'(MAX_ROW_BYTES))
		else $error("byte position left the row buffer range");

endmodule

FILE: design/b2r_fifo.sv
// Short job queue between the front end and the pixel sequencer.
module b2r_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  b2r_pkg::job_t wr_job,
	output logic          full,
	input  logic          rd,
	output b2r_pkg::job_t rd_job,
	output logic          empty
);

	b2r_pkg::job_t               mem_q [b2r_pkg::Q_DEPTH];
	logic [b2r_pkg::Q_AW-1:0]    wr_ptr_q;
	logic [b2r_pkg::Q_AW-1:0]    rd_ptr_q;
	logic [b2r_pkg::Q_AW:0]      cnt_q;

	assign full   = (cnt_q == (b2r_pkg::Q_AW + 1)'(b2r_pkg::Q_DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr && !full) begin
				wr_ptr_q <= wr_ptr_q + b2r_pkg::Q_AW'(1);
			end
			if (rd && !empty) begin
				rd_ptr_q <= rd_ptr_q + b2r_pkg::Q_AW'(1);
			end
			case ({wr && !full, rd && !empty})
				2'b10:   cnt_q <= cnt_q + (b2r_pkg::Q_AW + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (b2r_pkg::Q_AW + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (b2r_pkg::Q_AW + 1)'(b2r_pkg::Q_DEPTH))
		else $error("job queue count beyond depth");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr)
		else $error("job written while queue full");

endmodule

FILE: design/b2r_back.sv
// Pixel sequencer: expands each job into pixels, one transfer per cycle while pop is high.
module b2r_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  b2r_pkg::job_t        q_job,
	input  logic                 q_empty,
	output logic                 q_rd,
	input  logic                 pop,
	output logic                 empty,
	output b2r_pkg::pixel_item_t pixel_item
);

	b2r_pkg::job_t cur_q;
	logic          cur_valid_q;
	logic [2:0]    k_q;

	logic at_last;
	logic finishing;
	logic load;

	assign at_last   = (k_q == cur_q.last_idx);
	assign finishing = pop && cur_valid_q && at_last;
	assign load      = !q_empty && (!cur_valid_q || finishing);
	assign q_rd      = load;
	assign empty     = !cur_valid_q;

	// Mono bytes go out most significant bit first.
	always_comb begin
		if (cur_q.mono) begin
			pixel_item.pixel_rgb565 = cur_q.data[{1'b0, ~k_q}] ? b2r_pkg::WHITE
				: b2r_pkg::BLACK;
		end else begin
			pixel_item.pixel_rgb565 = cur_q.data;
		end
		pixel_item.row_end      = cur_q.row_end && at_last;
		pixel_item.last_of_item = at_last;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			k_q         <= '0;
		end else if (load) begin
			cur_valid_q <= 1'b1;
			k_q         <= '0;
		end else if (finishing) begin
			cur_valid_q <= 1'b0;
			k_q         <= '0;
		end else if (pop && cur_valid_q) begin
			k_q <= k_q + 3'd1;
		end
	end

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (k_q <= cur_q.last_idx))
		else $error("pixel index ran past its job");

endmodule

FILE: design/bmp_row_to_rgb565.sv
// Top level of the BMP row to RGB565 converter: front end, job queue and pixel sequencer.
// An accepted byte's job is written into the job queue, then loaded into the sequencer, which shows its first pixel.
// Input throughput: one byte per cycle while the four-entry job queue has room.
// Output throughput: one pixel per cycle from the sequencer while pop is high; a mono byte expands to up to 8 pixels.
// Color bytes make one pixel per three or four bytes and never limit the output side.
// Reset clears row position, the held color bytes and the queue; width 320, depth 24.
module bmp_row_to_rgb565 #(
	parameter int MAX_ROW_BYTES = 960
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  b2r_pkg::byte_item_t            byte_item,
	output logic                           empty,
	input  logic                           pop,
	output b2r_pkg::pixel_item_t           pixel_item,
	input  logic                           cfg_we,
	input  logic [0:0]                     cfg_idx,
	input  logic [b2r_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic          job_push;
	b2r_pkg::job_t job;
	b2r_pkg::job_t q_job;
	logic          q_empty;
	logic          q_rd;

	b2r_front #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.byte_item(byte_item),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.job_push (job_push),
		.job      (job)
	);

	b2r_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (job_push),
		.wr_job(job),
		.full  (full),
		.rd    (q_rd),
		.rd_job(q_job),
		.empty (q_empty)
	);

	b2r_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_job     (q_job),
		.q_empty   (q_empty),
		.q_rd      (q_rd),
		.pop       (pop),
		.empty     (empty),
		.pixel_item(pixel_item)
	);

endmodule
